// File: rtl/v3au_pkg.sv
// Shared types, constants and helper functions for the vector arithmetic unit.
// Used by every module in the rtl folder but the checker; depends on nothing else.
package v3au_pkg;

   // Fixed-point format and datapath widths.
   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int LANES     = 3;
   localparam int FUNC_W    = 4;

   // One square-root stage per result bit, one divide stage per quotient bit.
   localparam int SQ_STEPS  = DATA_W;
   localparam int QB        = FRAC_BITS + 1;

   // Stage counts along the pipeline.
   localparam int LANE_STAGES  = 2;
   localparam int MERGE_STAGES = 1;
   localparam int LATENCY      = LANE_STAGES + MERGE_STAGES + SQ_STEPS + QB;

   // Operation codes.
   typedef enum logic [FUNC_W-1:0] {
      FN_ADD   = 4'd0,
      FN_SUB   = 4'd1,
      FN_NEG   = 4'd2,
      FN_MUL   = 4'd3,
      FN_SCALE = 4'd4,
      FN_DOT   = 4'd5,
      FN_LEN   = 4'd6,
      FN_NORM  = 4'd7,
      FN_DIST  = 4'd8
   } func_type;

   // A clamped word and the flag that tells whether it was clamped.
   typedef struct packed {
      logic              flag;
      logic [DATA_W-1:0] val;
   } sat_type;

   // What one lane hands to the merging stage.
   typedef struct packed {
      func_type          func;
      logic [DATA_W-1:0] elem;
      logic              eflag;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] sq;
      logic [DATA_W-1:0] vec;
   } lane_out_type;

   // Sideband carried alongside the square-root pipeline.
   typedef struct packed {
      func_type                     func;
      logic [LANES-1:0][DATA_W-1:0] r;
      logic                         vflag;
      logic [DATA_W-1:0]            dot;
      logic                         dflag;
      logic [LANES-1:0][DATA_W-1:0] vec;
   } side_a_type;

   // Sideband carried alongside the divider pipeline.
   typedef struct packed {
      func_type                     func;
      logic [LANES-1:0][DATA_W-1:0] r;
      logic                         vflag;
      logic [DATA_W-1:0]            dot;
      logic                         dflag;
      logic [LANES-1:0]             neg;
      logic [DATA_W-1:0]            n;
   } side_b_type;

   // Clamp a wide signed value to the 32-bit range.
   function automatic sat_type sat32(input logic signed [SUM_W-1:0] v);
      sat_type s;
      logic    hi_ones;
      logic    hi_zeros;
      hi_ones  = &v[SUM_W-1:DATA_W-1];
      hi_zeros = ~|v[SUM_W-1:DATA_W-1];
      if (hi_ones || hi_zeros) begin
         s.flag = 1'b0;
         s.val  = v[DATA_W-1:0];
      end else begin
         s.flag = 1'b1;
         s.val  = v[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return s;
   endfunction

endpackage

// File: rtl/v3au_lane.sv
// One vector lane: add, subtract, negate, multiply and square for one component.
// Depends on v3au_pkg.
module v3au_lane (
   input  logic                      clock,
   input  logic                      enable,
   input  v3au_pkg::func_type        func,
   input  logic [v3au_pkg::DATA_W-1:0] a,
   input  logic [v3au_pkg::DATA_W-1:0] b,
   input  logic [v3au_pkg::DATA_W-1:0] k,
   output v3au_pkg::lane_out_type    lane_out
);
   import v3au_pkg::*;

   logic signed [DATA_W:0]   as_w;
   logic signed [DATA_W:0]   bs_w;
   logic signed [DATA_W:0]   sum_w;
   sat_type                  sum_sat;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic [DATA_W-1:0]        vec_in;

   func_type                 func_ff;
   logic [DATA_W-1:0]        res_ff;
   logic                     ovf_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [DATA_W-1:0]        vec_ff;

   logic signed [PROD_W-1:0] psh;
   sat_type                  prod_sat;
   logic [DATA_W-1:0]        mag;
   lane_out_type             out_in;
   lane_out_type             out_ff;

   // First stage: one adder for add, subtract and negate, one multiplier.
   always_comb begin
      as_w = {a[DATA_W-1], a};
      bs_w = {b[DATA_W-1], b};
      case (func)
         FN_ADD:  sum_w = as_w + bs_w;
         FN_NEG:  sum_w = -as_w;
         default: sum_w = as_w - bs_w;
      endcase
      sum_sat = sat32(SUM_W'(sum_w));
      mul_b   = (func == FN_SCALE) ? $signed(k) : $signed(b);
      prod_in = $signed(a) * mul_b;
      vec_in  = (func == FN_DIST) ? sum_sat.val : a;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         func_ff <= func;
         res_ff  <= sum_sat.val;
         ovf_ff  <= sum_sat.flag;
         prod_ff <= prod_in;
         vec_ff  <= vec_in;
      end
   end

   // Second stage: floor shift of the product and the square of the magnitude.
   always_comb begin
      psh      = prod_ff >>> FRAC_BITS;
      prod_sat = sat32(SUM_W'(psh));
      mag      = vec_ff[DATA_W-1] ? (~vec_ff + 1'b1) : vec_ff;
      out_in.func = func_ff;
      out_in.prod = prod_ff;
      out_in.sq   = PROD_W'(mag) * PROD_W'(mag);
      out_in.vec  = vec_ff;
      case (func_ff)
         FN_MUL, FN_SCALE: begin
            out_in.elem  = prod_sat.val;
            out_in.eflag = prod_sat.flag;
         end
         default: begin
            out_in.elem  = res_ff;
            out_in.eflag = ovf_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign lane_out = out_ff;

endmodule

// File: rtl/v3au_merge.sv
// Merging stage: combines the three lanes into the dot product, the sum of
// squares and the vector result. Depends on v3au_pkg.
module v3au_merge (
   input  logic                        clock,
   input  logic                        enable,
   input  v3au_pkg::lane_out_type      lanes [v3au_pkg::LANES],
   output v3au_pkg::side_a_type        side_out,
   output logic [v3au_pkg::PROD_W-1:0] sumsq
);
   import v3au_pkg::*;

   logic signed [SUM_W-1:0] dsum;
   logic signed [SUM_W-1:0] dsh;
   sat_type                 dsat;
   logic [PROD_W-1:0]       sq_in;
   side_a_type              side_in;
   side_a_type              side_ff;
   logic [PROD_W-1:0]       sumsq_ff;

   // Exact sum of the three products, then one floor shift and clamp.
   always_comb begin
      dsum = '0;
      sq_in = '0;
      side_in.vflag = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         dsum  = dsum + SUM_W'($signed(lanes[i].prod));
         sq_in = sq_in + lanes[i].sq;
         side_in.r[i]   = lanes[i].elem;
         side_in.vec[i] = lanes[i].vec;
         side_in.vflag  = side_in.vflag | lanes[i].eflag;
      end
      dsh          = dsum >>> FRAC_BITS;
      dsat         = sat32(dsh);
      side_in.func = lanes[0].func;
      side_in.dot  = dsat.val;
      side_in.dflag = dsat.flag;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff  <= side_in;
         sumsq_ff <= sq_in;
      end
   end

   assign side_out = side_ff;
   assign sumsq    = sumsq_ff;

endmodule

// File: rtl/v3au_sqrt.sv
// Pipelined integer square root, one result bit per stage, floor rounding.
// Depends on v3au_pkg.
module v3au_sqrt (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [v3au_pkg::PROD_W-1:0] x,
   output logic [v3au_pkg::DATA_W-1:0] root
);
   import v3au_pkg::*;

   logic [PROD_W-1:0] x_ff [SQ_STEPS];
   logic [PROD_W-1:0] r_ff [SQ_STEPS];

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
      localparam logic [PROD_W-1:0] BIT = PROD_W'(1) << (2 * (SQ_STEPS - 1 - i));
      logic [PROD_W-1:0] x_p;
      logic [PROD_W-1:0] r_p;
      logic [PROD_W-1:0] trial;
      logic [PROD_W-1:0] x_n;
      logic [PROD_W-1:0] r_n;

      // Try the current bit against the remaining radicand.
      always_comb begin
         if (i == 0) begin
            x_p = x;
            r_p = '0;
         end else begin
            x_p = x_ff[(i > 0) ? i - 1 : 0];
            r_p = r_ff[(i > 0) ? i - 1 : 0];
         end
         trial = r_p + BIT;
         if (x_p >= trial) begin
            x_n = x_p - trial;
            r_n = (r_p >> 1) + BIT;
         end else begin
            x_n = x_p;
            r_n = r_p >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i] <= x_n;
            r_ff[i] <= r_n;
         end
      end
   end

   assign root = r_ff[SQ_STEPS-1][DATA_W-1:0];

endmodule

// File: rtl/v3au_div.sv
// Pipelined restoring divider for normalize: (mag << FRAC_BITS) / n, one
// quotient bit per stage. Depends on v3au_pkg.
module v3au_div (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [v3au_pkg::DATA_W-1:0] mag,
   input  logic [v3au_pkg::DATA_W-1:0] n,
   output logic [v3au_pkg::QB-1:0]     quot
);
   import v3au_pkg::*;

   logic [DATA_W-1:0] rem_ff [QB];
   logic [QB-1:0]     q_ff   [QB];
   logic [QB-1:0]     lo_ff  [QB];
   logic [DATA_W-1:0] n_ff   [QB];

   for (genvar i = 0; i < QB; i++) begin : g_step
      logic [DATA_W-1:0] rem_p;
      logic [QB-1:0]     q_p;
      logic [QB-1:0]     lo_p;
      logic [DATA_W-1:0] n_p;
      logic [DATA_W:0]   t;
      logic              ge;
      logic [DATA_W:0]   diff;

      // The quotient never exceeds QB bits, so the upper dividend bits
      // start out as the partial remainder.
      always_comb begin
         if (i == 0) begin
            rem_p = {1'b0, mag[DATA_W-1:1]};
            q_p   = '0;
            lo_p  = {mag[0], {FRAC_BITS{1'b0}}};
            n_p   = n;
         end else begin
            rem_p = rem_ff[(i > 0) ? i - 1 : 0];
            q_p   = q_ff[(i > 0) ? i - 1 : 0];
            lo_p  = lo_ff[(i > 0) ? i - 1 : 0];
            n_p   = n_ff[(i > 0) ? i - 1 : 0];
         end
         t    = {rem_p, lo_p[QB-1]};
         ge   = (t >= {1'b0, n_p});
         diff = t - {1'b0, n_p};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i] <= ge ? diff[DATA_W-1:0] : t[DATA_W-1:0];
            q_ff[i]   <= {q_p[QB-2:0], ge};
            lo_ff[i]  <= lo_p << 1;
            n_ff[i]   <= n_p;
         end
      end
   end

   assign quot = q_ff[QB-1];

endmodule

// File: rtl/vector3_arith_unit_top.sv
// Top level of the three-component Q16.16 vector unit: lanes, merge, square
// root and divider pipelines, output register. Depends on v3au_pkg, v3au_lane,
// v3au_merge, v3au_sqrt and v3au_div.
//
//   Channel | Ports    | tdata (low bit up)                          | tuser
//   request | req_*    | a_x a_y a_z b_x b_y b_z scale_value (224)   | func (4)
//   result  | rsp_*    | r_x r_y r_z scalar_out (128)                | saturated (1)
//
// One request enters per cycle unless a stalled result holds the pipeline.
// Most of the pipeline lies in the 32-stage square root and the 17-stage divider.
// Reset is synchronous and empties the pipeline; no clearing pass is needed.
// A stalled result holds the whole pipeline, and req_tready drops with it.
module vector3_arith_unit_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [223:0] req_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scale_value
   input  logic [3:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // r_x, r_y, r_z, scalar_out
   output logic [0:0]   rsp_tuser    // saturated
);
   import v3au_pkg::*;

   logic              adv;
   func_type          func;
   logic [DATA_W-1:0] k;
   lane_out_type      lane_res [LANES];
   side_a_type        merge_side;
   logic [PROD_W-1:0] sumsq;
   logic [DATA_W-1:0] root;
   logic [QB-1:0]     quot [LANES];

   logic              vld_ff [LATENCY];
   side_a_type        side_a_ff [SQ_STEPS];
   side_b_type        side_b_ff [QB];
   side_b_type        side_b_in;
   side_b_type        fin;

   logic [127:0]      rsp_data_in;
   logic              rsp_sat_in;
   logic [127:0]      rsp_data_ff;
   logic              rsp_sat_ff;
   logic              rsp_valid_ff;

   // The pipeline advances whenever the output register can take a result.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign func       = func_type'(req_tuser);
   assign k          = req_tdata[7*DATA_W-1:6*DATA_W];

   // Per-component lanes.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      v3au_lane u_lane (
         .clock    (clock),
         .enable   (adv),
         .func     (func),
         .a        (req_tdata[i*DATA_W +: DATA_W]),
         .b        (req_tdata[(i+LANES)*DATA_W +: DATA_W]),
         .k        (k),
         .lane_out (lane_res[i])
      );
   end

   v3au_merge u_merge (
      .clock    (clock),
      .enable   (adv),
      .lanes    (lane_res),
      .side_out (merge_side),
      .sumsq    (sumsq)
   );

   v3au_sqrt u_sqrt (
      .clock  (clock),
      .enable (adv),
      .x      (sumsq),
      .root   (root)
   );

   // Sideband that travels beside the square root.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_a_ff[0] <= merge_side;
         for (int i = 1; i < SQ_STEPS; i++) begin
            side_a_ff[i] <= side_a_ff[i-1];
         end
      end
   end

   // Divider lanes take the magnitudes of A and the unclamped length.
   for (genvar i = 0; i < LANES; i++) begin : g_div
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] m;
      assign v = side_a_ff[SQ_STEPS-1].vec[i];
      assign m = v[DATA_W-1] ? (~v + 1'b1) : v;
      v3au_div u_div (
         .clock  (clock),
         .enable (adv),
         .mag    (m),
         .n      (root),
         .quot   (quot[i])
      );
   end

   // Sideband that travels beside the divider.
   always_comb begin
      side_b_in.func  = side_a_ff[SQ_STEPS-1].func;
      side_b_in.r     = side_a_ff[SQ_STEPS-1].r;
      side_b_in.vflag = side_a_ff[SQ_STEPS-1].vflag;
      side_b_in.dot   = side_a_ff[SQ_STEPS-1].dot;
      side_b_in.dflag = side_a_ff[SQ_STEPS-1].dflag;
      side_b_in.n     = root;
      for (int i = 0; i < LANES; i++) begin
         side_b_in.neg[i] = side_a_ff[SQ_STEPS-1].vec[i][DATA_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_b_ff[0] <= side_b_in;
         for (int i = 1; i < QB; i++) begin
            side_b_ff[i] <= side_b_ff[i-1];
         end
      end
   end

   // Valid bits follow the payload through every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_tvalid;
         for (int i = 1; i < LATENCY; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Final selection of the result by operation.
   assign fin = side_b_ff[QB-1];

   always_comb begin
      rsp_data_in = '0;
      rsp_sat_in  = 1'b0;
      case (fin.func)
         FN_ADD, FN_SUB, FN_NEG, FN_MUL, FN_SCALE: begin
            rsp_data_in[3*DATA_W-1:0] = fin.r;
            rsp_sat_in                = fin.vflag;
         end
         FN_DOT: begin
            rsp_data_in[4*DATA_W-1:3*DATA_W] = fin.dot;
            rsp_sat_in                       = fin.dflag;
         end
         FN_LEN: begin
            rsp_data_in[4*DATA_W-1:3*DATA_W] =
               fin.n[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : fin.n;
            rsp_sat_in = fin.n[DATA_W-1];
         end
         FN_NORM: begin
            // A zero-length vector is all zeros and passes through as such.
            if (fin.n != '0) begin
               for (int i = 0; i < LANES; i++) begin
                  rsp_data_in[i*DATA_W +: DATA_W] = fin.neg[i]
                     ? (~DATA_W'(quot[i]) + 1'b1) : DATA_W'(quot[i]);
               end
            end
         end
         FN_DIST: begin
            rsp_data_in[4*DATA_W-1:3*DATA_W] =
               fin.n[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : fin.n;
            rsp_sat_in = fin.vflag | fin.n[DATA_W-1];
         end
         default: begin
            rsp_data_in = '0;
            rsp_sat_in  = 1'b0;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

endmodule

// File: rtl/v3au_checker.sv
// Port-level checks for the vector unit, bound to the top level.
// Depends only on the top level's ports.
module v3au_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [223:0] req_tdata,
   input logic [3:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // The result leaves the channel empty after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // With no result waiting, requests are always taken.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked while output is empty");

   // A stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Vector and scalar results never both carry data.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[127:96] == 32'd0 || rsp_tdata[95:0] == 96'd0))
      else $error("vector and scalar fields both nonzero");

   // A saturated result shows a clamped component or a nonzero scalar.
   a_sat_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[31:0] == 32'h7fffffff || rsp_tdata[31:0] == 32'h80000000 ||
          rsp_tdata[63:32] == 32'h7fffffff || rsp_tdata[63:32] == 32'h80000000 ||
          rsp_tdata[95:64] == 32'h7fffffff || rsp_tdata[95:64] == 32'h80000000 ||
          rsp_tdata[127:96] != 32'd0))
      else $error("saturation flag without a clamped value");

endmodule

bind vector3_arith_unit_top v3au_checker u_v3au_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/tb.sv
// Self-checking testbench for the Q16.16 vector arithmetic unit.
// Drives the request and result streams with random idling; checks each result
// against the table or predictor. Depends on v3au_pkg, vector3_arith_unit_top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import v3au_pkg::*;

   localparam int N_RANDOM   = 1500;
   localparam int QUIET_TAIL = 150;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_WAIT = 60;
   localparam int HOLD_LONG  = 300;

   localparam logic [31:0] W_MAX  = 32'h7fff_ffff;
   localparam logic [31:0] W_MIN  = 32'h8000_0000;
   localparam logic [31:0] W_ONE  = 32'h0001_0000;
   localparam logic [31:0] W_MONE = 32'hffff_0000;
   localparam logic [3:0]  FN_UNUSED_LO = 4'd9;
   localparam logic [3:0]  FN_UNUSED_HI = 4'd15;

   typedef struct {
      logic [3:0]  func;
      logic [31:0] ax, ay, az, bx, by, bz, k;
   } vec_request_type;

   typedef struct {
      logic [31:0] rx, ry, rz, sc;
      logic        sat;
   } vec_result_type;

   // One row of the directed table; known rows carry a hand-written answer.
   typedef struct {
      logic [3:0]  func;
      logic [31:0] ax, ay, az, bx, by, bz, k;
      bit          known;
      logic [31:0] ex, ey, ez, es;
      logic        esat;
   } vec_case_type;

   vec_case_type directed_cases [] = '{
      '{FN_ADD,   0, 0, 0, 0, 0, 0, 0,                       1, 0, 0, 0, 0, 0},
      '{FN_ADD,   W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0,
                  1, W_MAX, W_MAX, W_MAX, 0, 1},
      '{FN_ADD,   W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 0,
                  1, W_MIN, W_MIN, W_MIN, 0, 1},
      '{FN_SUB,   W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 0,
                  1, W_MIN, W_MIN, W_MIN, 0, 1},
      '{FN_NEG,   W_MIN, W_MIN, W_MIN, 0, 0, 0, 0,           1, W_MAX, W_MAX, W_MAX, 0, 1},
      '{FN_NEG,   W_MAX, W_MAX, W_MAX, 0, 0, 0, 0,
                  1, 32'h8000_0001, 32'h8000_0001, 32'h8000_0001, 0, 0},
      '{FN_MUL,   W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 0,
                  1, W_ONE, W_ONE, W_ONE, 0, 0},
      '{FN_MUL,   W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0,
                  1, W_MAX, W_MAX, W_MAX, 0, 1},
      '{FN_MUL,   W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 0,
                  1, W_MIN, W_MIN, W_MIN, 0, 1},
      '{FN_SCALE, W_ONE, 32'h0002_8000, W_MONE, 0, 0, 0, 32'h0003_4000,
                  0, 0, 0, 0, 0, 0},
      '{FN_SCALE, W_MIN, W_MIN, W_MIN, 0, 0, 0, W_MIN,       1, W_MAX, W_MAX, W_MAX, 0, 1},
      '{FN_DOT,   W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, W_ONE, 0,
                  1, 0, 0, 0, 32'h0003_0000, 0},
      '{FN_DOT,   W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0, 1, 0, 0, 0, W_MAX, 1},
      '{FN_LEN,   32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0,
                  1, 0, 0, 0, 32'h0005_0000, 0},
      '{FN_LEN,   W_MAX, W_MAX, W_MAX, 0, 0, 0, 0,           1, 0, 0, 0, W_MAX, 1},
      '{FN_LEN,   W_MIN, W_MIN, W_MIN, 0, 0, 0, 0,           1, 0, 0, 0, W_MAX, 1},
      '{FN_NORM,  0, 0, 0, W_MAX, W_MIN, W_ONE, W_MAX,       1, 0, 0, 0, 0, 0},
      '{FN_NORM,  32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{FN_NORM,  W_MIN, 0, 0, 0, 0, 0, 0,                   1, W_MONE, 0, 0, 0, 0},
      '{FN_NORM,  32'hffff_fffd, 32'h0000_0004, 32'h0123_4567, 0, 0, 0, 0,
                  0, 0, 0, 0, 0, 0},
      '{FN_DIST,  W_MIN, 0, W_MAX, W_MAX, W_ONE, W_MIN, 0,   0, 0, 0, 0, 0, 0},
      '{FN_DIST,  W_ONE, W_MONE, W_MAX, W_ONE, W_MONE, W_MAX, 0, 1, 0, 0, 0, 0, 0},
      '{FN_UNUSED_LO, W_MAX, W_MIN, W_ONE, W_MAX, W_MIN, W_ONE, W_MAX,
                  1, 0, 0, 0, 0, 0},
      '{FN_UNUSED_HI, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                  1, 0, 0, 0, 0, 0}
   };

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [223:0] req_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, scale_value
   logic [3:0]   req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // r_x, r_y, r_z, scalar_out
   logic [0:0]   rsp_tuser;   // saturated

   vec_result_type pending_results [$];
   int             requests_sent;
   int             results_seen;
   int             mismatches;
   int             saturated_seen;
   int             idle_cycles;
   int             func_counts [16];
   bit             stimulus_done;
   bit             quiet_tail;

   vector3_arith_unit_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock and a single reset at the start.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // Clamp to the signed 32-bit range and note whether a clamp happened.
   function automatic longint clamp_word(input longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Bitwise square root, rounded down.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bitpos;
      root   = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > x) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (x >= root + bitpos) begin
            x    = x - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   // Exact floor length of a vector whose parts lie in the 32-bit range.
   function automatic logic [63:0] vec_length(input longint v0, input longint v1,
                                              input longint v2);
      logic [63:0] m0, m1, m2;
      m0 = (v0 < 0) ? -v0 : v0;
      m1 = (v1 < 0) ? -v1 : v1;
      m2 = (v2 < 0) ? -v2 : v2;
      return floor_sqrt(m0 * m0 + m1 * m1 + m2 * m2);
   endfunction

   // Expected result of one vector request.
   function automatic vec_result_type predict_vector_op(input vec_request_type rq);
      longint         a [3];
      longint         b [3];
      longint         r [3];
      longint         d [3];
      longint         k, sc, p, h, hi, lo;
      logic [63:0]    n, mag, quo;
      bit             sat;
      vec_result_type res;
      a[0] = longint'($signed(rq.ax));
      a[1] = longint'($signed(rq.ay));
      a[2] = longint'($signed(rq.az));
      b[0] = longint'($signed(rq.bx));
      b[1] = longint'($signed(rq.by));
      b[2] = longint'($signed(rq.bz));
      k    = longint'($signed(rq.k));
      for (int i = 0; i < 3; i++) r[i] = 0;
      sc  = 0;
      sat = 1'b0;
      case (rq.func)
         FN_ADD:   for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], sat);
         FN_SUB:   for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], sat);
         FN_NEG:   for (int i = 0; i < 3; i++) r[i] = clamp_word(-a[i], sat);
         FN_MUL:   for (int i = 0; i < 3; i++)
                      r[i] = clamp_word((a[i] * b[i]) >>> FRAC_BITS, sat);
         FN_SCALE: for (int i = 0; i < 3; i++)
                      r[i] = clamp_word((a[i] * k) >>> FRAC_BITS, sat);
         FN_DOT: begin
            // Sum the floored products and their fractional remainders apart.
            hi = 0;
            lo = 0;
            for (int i = 0; i < 3; i++) begin
               p  = a[i] * b[i];
               h  = p >>> FRAC_BITS;
               hi = hi + h;
               lo = lo + (p - (h <<< FRAC_BITS));
            end
            sc = clamp_word(hi + (lo >>> FRAC_BITS), sat);
         end
         FN_LEN: begin
            n  = vec_length(a[0], a[1], a[2]);
            sc = clamp_word(longint'(n), sat);
         end
         FN_NORM: begin
            // A zero vector passes through; otherwise divide by the raw length.
            n = vec_length(a[0], a[1], a[2]);
            for (int i = 0; i < 3; i++) begin
               if (n == 0) begin
                  r[i] = a[i];
               end else begin
                  mag  = (a[i] < 0) ? -a[i] : a[i];
                  quo  = (mag << FRAC_BITS) / n;
                  r[i] = clamp_word((a[i] < 0) ? -longint'(quo) : longint'(quo), sat);
               end
            end
         end
         FN_DIST: begin
            for (int i = 0; i < 3; i++) d[i] = clamp_word(a[i] - b[i], sat);
            n  = vec_length(d[0], d[1], d[2]);
            sc = clamp_word(longint'(n), sat);
         end
         default: ;
      endcase
      res.rx  = r[0][31:0];
      res.ry  = r[1][31:0];
      res.rz  = r[2][31:0];
      res.sc  = sc[31:0];
      res.sat = sat;
      return res;
   endfunction

   // Operand word biased toward the edges of the range.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return W_MAX;
         2:       return W_MIN;
         3:       return $urandom_range(0, 1) ? W_ONE : W_MONE;
         4, 5:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom;
      endcase
   endfunction

   // Present one request and wait for it to be accepted.
   task automatic send_request(input vec_request_type rq, input bit known,
                               input vec_result_type typed);
      req_tvalid <= 1'b1;
      req_tuser  <= rq.func;
      req_tdata  <= {rq.k, rq.bz, rq.by, rq.bx, rq.az, rq.ay, rq.ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(known ? typed : predict_vector_op(rq));
      func_counts[rq.func]++;
      requests_sent++;
   endtask

   // Request side: directed table, then random requests with idle bursts.
   initial begin
      vec_request_type rq;
      vec_result_type  typed;
      int              total;
      int              r;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      total      = directed_cases.size() + N_RANDOM;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < total; i++) begin
         if (i >= total - QUIET_TAIL) quiet_tail = 1'b1;
         // Idle bursts come in alternating stretches of the run.
         if (!quiet_tail && ((i / 200) % 2 == 0) && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         if (i < directed_cases.size()) begin
            rq.func  = directed_cases[i].func;
            rq.ax    = directed_cases[i].ax;
            rq.ay    = directed_cases[i].ay;
            rq.az    = directed_cases[i].az;
            rq.bx    = directed_cases[i].bx;
            rq.by    = directed_cases[i].by;
            rq.bz    = directed_cases[i].bz;
            rq.k     = directed_cases[i].k;
            typed.rx  = directed_cases[i].ex;
            typed.ry  = directed_cases[i].ey;
            typed.rz  = directed_cases[i].ez;
            typed.sc  = directed_cases[i].es;
            typed.sat = directed_cases[i].esat;
            send_request(rq, directed_cases[i].known, typed);
         end else begin
            r       = $urandom_range(0, 19);
            rq.func = (r < 18) ? 4'(r % 9) : 4'($urandom_range(9, 15));
            rq.ax   = pick_word();
            rq.ay   = pick_word();
            rq.az   = pick_word();
            rq.bx   = pick_word();
            rq.by   = pick_word();
            rq.bz   = pick_word();
            rq.k    = pick_word();
            send_request(rq, 1'b0, typed);
         end
      end
      req_tvalid    <= 1'b0;
      stimulus_done  = 1'b1;
   end

   // Result side: random stall bursts, one long hold-off, none at the tail.
   initial begin
      bit held_long;
      rsp_tready = 1'b1;
      held_long  = 1'b0;
      @(posedge clock);
      forever begin
         if (quiet_tail) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (!held_long && requests_sent >= 400) begin
            // Hold long enough for the pipeline to fill and block requests.
            rsp_tready <= 1'b0;
            repeat (HOLD_LONG) @(posedge clock);
            held_long = 1'b1;
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if (!quiet_tail) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 19)) @(posedge clock);
            end
         end
      end
   end

   // Compare each result with the oldest expectation; watch for a stuck run.
   always @(posedge clock) begin
      vec_result_type want;
      vec_result_type got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.rx  = rsp_tdata[31:0];
            got.ry  = rsp_tdata[63:32];
            got.rz  = rsp_tdata[95:64];
            got.sc  = rsp_tdata[127:96];
            got.sat = rsp_tuser[0];
            results_seen++;
            if (got.sat) saturated_seen++;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result %h %h %h %h sat=%b",
                           got.rx, got.ry, got.rz, got.sc, got.sat);
            end else begin
               want = pending_results.pop_front();
               if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz ||
                   got.sc !== want.sc || got.sat !== want.sat) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Result %0d mismatch:", results_seen);
                     $display("  expected %h %h %h %h sat=%b",
                              want.rx, want.ry, want.rz, want.sc, want.sat);
                     $display("  actual   %h %h %h %h sat=%b",
                              got.rx, got.ry, got.rz, got.sc, got.sat);
                  end
               end
            end
         end
      end
   end

   // Wait for the last result, let the pipeline settle, then report.
   initial begin
      idle_cycles = 0;
      wait (stimulus_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0) mismatches++;
      $display("Checked %0d results from %0d requests, %0d of them saturated.",
               results_seen, requests_sent, saturated_seen);
      $display("Ops add..dist: %0d %0d %0d %0d %0d %0d %0d %0d %0d; mismatches: %0d",
               func_counts[0], func_counts[1], func_counts[2], func_counts[3],
               func_counts[4], func_counts[5], func_counts[6], func_counts[7],
               func_counts[8], mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/v3au_pkg.sv
rtl/v3au_lane.sv
rtl/v3au_merge.sv
rtl/v3au_sqrt.sv
rtl/v3au_div.sv
rtl/vector3_arith_unit_top.sv
rtl/v3au_checker.sv
test/tb.sv
